// ----- rtl/tsba_pkg.sv -----
// Package: shared types, codes and sizes of the transient slot bump allocator.
package tsba_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int IDX_W     = 4;
    localparam int BYTES_W   = 29;
    localparam int TOKEN_W   = 64;
    localparam int BASE_W    = 48;
    localparam int COUNT_W   = 5;
    localparam int SOFF_W    = IDX_W + BYTES_W;
    localparam int SBASE_W   = BASE_W + 1;
    localparam int ALIGNED_W = BASE_W + 2;
    localparam int LOCAL_W   = BYTES_W + 1;
    localparam int NEED_W    = BYTES_W + 2;
    localparam int ADDR_W    = 49;
    localparam int ROFF_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = BASE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ADDRESS = 2'd0,
        CFG_SLOT_BYTES   = 2'd1,
        CFG_SLOT_COUNT   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_BEGIN    = 2'd0,
        OP_ALLOCATE = 2'd1,
        OP_SEAL     = 2'd2,
        OP_ABORT    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_EMPTY  = 2'd0,
        ST_OPEN   = 2'd1,
        ST_SEALED = 2'd2
    } slot_state_t;

    typedef enum logic [2:0] {
        RC_OK        = 3'd0,
        RC_PRECOND   = 3'd1,
        RC_BUSY      = 3'd2,
        RC_MISMATCH  = 3'd3,
        RC_EXHAUSTED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ALIGN,
        S_OFFSET,
        S_DONE
    } fsm_state_t;

    typedef struct packed {
        op_t                  op;
        logic [IDX_W-1:0]     slot_sel;
        logic [TOKEN_W-1:0]   token;
        logic                 work_done;
        logic [BYTES_W-1:0]   alloc_bytes;
        logic [BYTES_W-1:0]   alignment;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [ADDR_W-1:0]    address;
        logic [ROFF_W-1:0]    region_offset;
        logic [BYTES_W-1:0]   slice_bytes;
    } rsp_t;

    typedef struct packed {
        slot_state_t          state;
        logic [BYTES_W-1:0]   used;
        logic [TOKEN_W-1:0]   seal_token;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic req_ready;
        logic load;
        logic align;
        logic offset;
        logic commit;
    } ctl_t;

endpackage

// ----- rtl/tsba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module tsba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/tsba_fsm.sv -----
// Sequencer: steps one word through load, align, offset and commit.
module tsba_fsm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            rsp_free,
    output tsba_pkg::ctl_t  ctl
);

    tsba_pkg::fsm_state_t state_reg;
    tsba_pkg::fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsba_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tsba_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = tsba_pkg::S_LOAD;
                end
            end
            tsba_pkg::S_LOAD:   state_next = tsba_pkg::S_ALIGN;
            tsba_pkg::S_ALIGN:  state_next = tsba_pkg::S_OFFSET;
            tsba_pkg::S_OFFSET: state_next = tsba_pkg::S_DONE;
            tsba_pkg::S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = tsba_pkg::S_IDLE;
                end
            end
            default: state_next = tsba_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        case (state_reg)
            tsba_pkg::S_IDLE:   ctl.req_ready = 1'b1;
            tsba_pkg::S_LOAD:   ctl.load = 1'b1;
            tsba_pkg::S_ALIGN:  ctl.align = 1'b1;
            tsba_pkg::S_OFFSET: ctl.offset = 1'b1;
            tsba_pkg::S_DONE:   ctl.commit = rsp_free;
            default:            ctl = '0;
        endcase
    end

endmodule

// ----- rtl/transient_slot_bump_allocator.sv -----
// Top level: slot table in RAM, bump-allocation datapath and response register.
//
// Words arrive on req (req_valid/req_ready) and one response word per request
// leaves on rsp (rsp_valid/rsp_ready). Configuration is written through
// cfg_we/cfg_index/cfg_data with no wait; index 0 base address, 1 slot size,
// 2 slot count. Writes must be made only while no request is in flight;
// the block itself does not enforce this. A request is taken only in the
// idle cycle. The slot entry is read from the slot RAM, then the slot base,
// aligned address and local offset are formed in three registered steps,
// and the decision and write-back happen in the commit step after them.
// The block returns to idle as the response becomes valid; it takes no new
// request before the last one is committed.
// The response sits in an output register; while rsp_ready is low the block
// finishes the next request up to its commit step and holds there.
// Reset empties every slot at once through per-slot valid flags (an entry
// not yet written reads as all zero) and loads the register defaults:
// base address 0, slot size 4096 bytes, slot count 1.
module transient_slot_bump_allocator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  tsba_pkg::req_t                      req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output tsba_pkg::rsp_t                      rsp,
    input  logic                                cfg_we,
    input  logic [tsba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tsba_pkg::CFG_W-1:0]          cfg_data
);

    tsba_pkg::ctl_t ctl;
    logic           rsp_free;
    logic           accept;

    logic [tsba_pkg::BASE_W-1:0]  base_address_reg;
    logic [tsba_pkg::BYTES_W-1:0] slot_bytes_reg;
    logic [tsba_pkg::COUNT_W-1:0] slot_count_reg;

    logic [tsba_pkg::MAX_SLOTS-1:0] slot_valid_reg;
    logic [tsba_pkg::MAX_SLOTS-1:0] slot_valid_next;
    logic                           rsp_valid_reg;
    logic                           rsp_valid_next;

    tsba_pkg::req_t                  req_reg;
    logic [tsba_pkg::SOFF_W-1:0]     soff_reg;
    logic [tsba_pkg::SOFF_W-1:0]     soff_next;
    tsba_pkg::entry_t                entry_reg;
    tsba_pkg::entry_t                entry_next;
    logic [tsba_pkg::SBASE_W-1:0]    sbase_reg;
    logic [tsba_pkg::SBASE_W-1:0]    sbase_next;
    logic [tsba_pkg::ALIGNED_W-1:0]  aligned_reg;
    logic [tsba_pkg::ALIGNED_W-1:0]  aligned_next;
    logic [tsba_pkg::LOCAL_W-1:0]    offset_reg;
    logic [tsba_pkg::LOCAL_W-1:0]    offset_next;
    tsba_pkg::rsp_t                  rsp_reg;
    tsba_pkg::rsp_t                  rsp_next;

    logic [tsba_pkg::ENTRY_W-1:0]    ram_rdata;
    tsba_pkg::entry_t                wr_entry;

    logic [tsba_pkg::BYTES_W-1:0]    align_m1;
    logic [tsba_pkg::ALIGNED_W-1:0]  align_sum;
    logic [tsba_pkg::NEED_W-1:0]     need;
    logic [tsba_pkg::SOFF_W:0]       roff_sum;
    logic                            index_ok;
    logic                            align_ok;
    logic                            exhausted;

    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign accept    = ctl.req_ready && req_valid;
    assign req_ready = ctl.req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    tsba_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .rsp_free  (rsp_free),
        .ctl       (ctl)
    );

    tsba_ram #(
        .WIDTH (tsba_pkg::ENTRY_W),
        .DEPTH (tsba_pkg::MAX_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ctl.commit),
        .waddr (req_reg.slot_sel),
        .wdata (wr_entry),
        .re    (accept),
        .raddr (req.slot_sel),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= '0;
            slot_bytes_reg   <= tsba_pkg::BYTES_W'(4096);
            slot_count_reg   <= tsba_pkg::COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tsba_pkg::CFG_BASE_ADDRESS: base_address_reg <= cfg_data;
                tsba_pkg::CFG_SLOT_BYTES:   slot_bytes_reg <= cfg_data[tsba_pkg::BYTES_W-1:0];
                tsba_pkg::CFG_SLOT_COUNT:   slot_count_reg <= cfg_data[tsba_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        if (ctl.commit)
        begin
            slot_valid_next[req_reg.slot_sel] = 1'b1;
        end
        rsp_valid_next = rsp_valid_reg;
        if (ctl.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // address path
    assign soff_next  = tsba_pkg::SOFF_W'(req.slot_sel) * tsba_pkg::SOFF_W'(slot_bytes_reg);
    assign entry_next = slot_valid_reg[req_reg.slot_sel] ? tsba_pkg::entry_t'(ram_rdata) : '0;
    assign sbase_next = tsba_pkg::SBASE_W'(base_address_reg) + tsba_pkg::SBASE_W'(soff_reg);
    assign align_m1   = req_reg.alignment - tsba_pkg::BYTES_W'(1);
    assign align_sum  = tsba_pkg::ALIGNED_W'(sbase_reg) + tsba_pkg::ALIGNED_W'(entry_reg.used)
                      + tsba_pkg::ALIGNED_W'(align_m1);
    assign aligned_next = align_sum & ~tsba_pkg::ALIGNED_W'(align_m1);
    assign offset_next  = tsba_pkg::LOCAL_W'(aligned_reg - tsba_pkg::ALIGNED_W'(sbase_reg));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req;
            soff_reg <= soff_next;
        end
        if (ctl.load)
        begin
            entry_reg <= entry_next;
            sbase_reg <= sbase_next;
        end
        if (ctl.align)
        begin
            aligned_reg <= aligned_next;
        end
        if (ctl.offset)
        begin
            offset_reg <= offset_next;
        end
        if (ctl.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // decision and write-back
    assign index_ok  = {1'b0, req_reg.slot_sel} < slot_count_reg;
    assign align_ok  = (req_reg.alignment != '0) && ((req_reg.alignment & align_m1) == '0);
    assign need      = tsba_pkg::NEED_W'(offset_reg) + tsba_pkg::NEED_W'(req_reg.alloc_bytes);
    assign exhausted = need > tsba_pkg::NEED_W'(slot_bytes_reg);
    assign roff_sum  = (tsba_pkg::SOFF_W + 1)'(soff_reg) + (tsba_pkg::SOFF_W + 1)'(offset_reg);

    always_comb
    begin
        wr_entry = entry_reg;
        rsp_next = '0;
        rsp_next.status = tsba_pkg::RC_OK;
        if (!index_ok)
        begin
            rsp_next.status = tsba_pkg::RC_PRECOND;
        end
        else
        begin
            case (req_reg.op)
                tsba_pkg::OP_BEGIN:
                begin
                    if (entry_reg.state == tsba_pkg::ST_OPEN)
                    begin
                        rsp_next.status = tsba_pkg::RC_BUSY;
                    end
                    else if (entry_reg.state == tsba_pkg::ST_SEALED
                             && !req_reg.work_done)
                    begin
                        rsp_next.status = tsba_pkg::RC_BUSY;
                    end
                    else if (entry_reg.state == tsba_pkg::ST_SEALED
                             && (req_reg.token == '0
                                 || req_reg.token != entry_reg.seal_token))
                    begin
                        rsp_next.status = tsba_pkg::RC_MISMATCH;
                    end
                    else
                    begin
                        wr_entry.state      = tsba_pkg::ST_OPEN;
                        wr_entry.used       = '0;
                        wr_entry.seal_token = '0;
                    end
                end
                tsba_pkg::OP_ALLOCATE:
                begin
                    if (req_reg.alloc_bytes == '0 || !align_ok)
                    begin
                        rsp_next.status = tsba_pkg::RC_PRECOND;
                    end
                    else if (entry_reg.state != tsba_pkg::ST_OPEN)
                    begin
                        rsp_next.status = tsba_pkg::RC_BUSY;
                    end
                    else if (exhausted)
                    begin
                        rsp_next.status = tsba_pkg::RC_EXHAUSTED;
                    end
                    else
                    begin
                        wr_entry.used          = need[tsba_pkg::BYTES_W-1:0];
                        rsp_next.address       = aligned_reg[tsba_pkg::ADDR_W-1:0];
                        rsp_next.region_offset = roff_sum[tsba_pkg::ROFF_W-1:0];
                        rsp_next.slice_bytes   = req_reg.alloc_bytes;
                    end
                end
                tsba_pkg::OP_SEAL:
                begin
                    if (req_reg.token == '0)
                    begin
                        rsp_next.status = tsba_pkg::RC_PRECOND;
                    end
                    else if (entry_reg.state != tsba_pkg::ST_OPEN)
                    begin
                        rsp_next.status = tsba_pkg::RC_BUSY;
                    end
                    else
                    begin
                        wr_entry.seal_token = req_reg.token;
                        wr_entry.state      = tsba_pkg::ST_SEALED;
                    end
                end
                tsba_pkg::OP_ABORT:
                begin
                    if (entry_reg.state != tsba_pkg::ST_OPEN)
                    begin
                        rsp_next.status = tsba_pkg::RC_BUSY;
                    end
                    else
                    begin
                        wr_entry.used  = '0;
                        wr_entry.state = tsba_pkg::ST_EMPTY;
                    end
                end
                default:
                begin
                    rsp_next.status = tsba_pkg::RC_PRECOND;
                end
            endcase
        end
    end

endmodule
